// ----- hw/rtl/cfd_pkg.sv -----
package cfd_pkg;

  localparam int FRAME_SIZE   = 10;
  localparam int TEXT_FIRST   = 3;
  localparam int TEXT_BYTES   = FRAME_SIZE - TEXT_FIRST;
  localparam int STORED_BYTES = TEXT_BYTES - 1;
  localparam int TEXT_W       = 8 * TEXT_BYTES;
  localparam int CNT_W        = 4;
  localparam int STORE_IDX_W  = $clog2(STORED_BYTES);
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CNT_W-1:0] TEXT_FIRST_POS = CNT_W'(TEXT_FIRST);
  localparam logic [CNT_W-1:0] LAST_POS       = CNT_W'(FRAME_SIZE - 1);

  localparam logic [7:0]  START_BYTE_RESET      = 8'h80;
  localparam logic [15:0] EXPECTED_LENGTH_RESET = 16'd7;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE      = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_LENGTH = CFG_INDEX_W'(1);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_SEQ,
    PH_HDR,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [15:0] expected_length;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [TEXT_W-1:0] text;
  } result_t;

endpackage

// ----- hw/rtl/cfd_cfg.sv -----
module cfd_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cfd_pkg::cfg_t                  cfg
);
  import cfd_pkg::*;

  logic [7:0]  start_byte;
  logic [15:0] expected_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte      <= START_BYTE_RESET;
      expected_length <= EXPECTED_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_BYTE:      start_byte      <= cfg_data[7:0];
        CFG_EXPECTED_LENGTH: expected_length <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg.start_byte      = start_byte;
  assign cfg.expected_length = expected_length;

endmodule

// ----- hw/rtl/cfd_parser.sv -----
module cfd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  cfd_pkg::cfg_t     cfg,
  output cfd_pkg::result_t  res
);
  import cfd_pkg::*;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       len_lo, len_lo_next;
  logic [7:0]       frame_bytes [STORED_BYTES];
  logic             store;
  logic [CNT_W-1:0] store_pos;
  logic [7:0]       sum_add;

  assign sum_add   = running_sum + rx_byte;
  assign store_pos = byte_count - TEXT_FIRST_POS;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_count  <= '0;
      running_sum <= '0;
      len_lo      <= '0;
    end else begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
      len_lo      <= len_lo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      frame_bytes[store_pos[STORE_IDX_W-1:0]] <= rx_byte;
    end
  end

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    len_lo_next      = len_lo;
    store            = 1'b0;
    res.valid        = 1'b0;
    for (int i = 0; i < STORED_BYTES; i++) begin
      res.text[8*i +: 8] = frame_bytes[i];
    end
    res.text[TEXT_W-1 -: 8] = rx_byte;
    if (accept) begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == cfg.start_byte) begin
            phase_next       = PH_LEN_LO;
            byte_count_next  = CNT_W'(1);
            running_sum_next = rx_byte;
          end else begin
            byte_count_next = '0;
          end
        end
        PH_LEN_LO: begin
          len_lo_next      = rx_byte;
          byte_count_next  = byte_count + 1'b1;
          running_sum_next = sum_add;
          phase_next       = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if ({rx_byte, len_lo} == cfg.expected_length) begin
            byte_count_next  = byte_count + 1'b1;
            running_sum_next = sum_add;
            phase_next       = PH_SEQ;
          end else begin
            byte_count_next  = '0;
            running_sum_next = '0;
            phase_next       = PH_HUNT;
          end
        end
        PH_SEQ: begin
          store            = 1'b1;
          byte_count_next  = byte_count + 1'b1;
          running_sum_next = sum_add;
          phase_next       = PH_HDR;
        end
        PH_HDR: begin
          store            = 1'b1;
          byte_count_next  = byte_count + 1'b1;
          running_sum_next = sum_add;
          phase_next       = PH_DATA;
        end
        PH_DATA: begin
          if (byte_count == LAST_POS) begin
            res.valid        = (sum_add == 8'd0);
            byte_count_next  = '0;
            running_sum_next = '0;
            phase_next       = PH_HUNT;
          end else begin
            store            = 1'b1;
            byte_count_next  = byte_count + 1'b1;
            running_sum_next = sum_add;
          end
        end
        default: begin
          byte_count_next  = '0;
          running_sum_next = '0;
          phase_next       = PH_HUNT;
        end
      endcase
    end
  end

  a_res_at_last: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (phase == PH_DATA && byte_count == LAST_POS))
    else $error("result outside last frame byte");

  a_res_resync: assert property (@(posedge clk) disable iff (rst)
    res.valid |=> (phase == PH_HUNT && byte_count == '0 && running_sum == '0))
    else $error("no resync after result");

  a_hunt_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT) |-> (byte_count == '0))
    else $error("count not cleared while hunting");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= LAST_POS)
    else $error("byte count past frame end");

endmodule

// ----- hw/rtl/cfd_out_buf.sv -----
module cfd_out_buf (
  input  logic                      clk,
  input  logic                      rst,
  input  cfd_pkg::result_t          res,
  output logic                      full,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [cfd_pkg::TEXT_W-1:0] reading_text
);
  import cfd_pkg::*;

  logic              skid_valid;
  logic [TEXT_W-1:0] skid_text;
  logic              out_take;

  assign out_take = out_valid && !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (res.valid) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        reading_text <= skid_text;
      end
    end else if (res.valid) begin
      if (!out_valid || out_take) begin
        reading_text <= res.text;
      end else begin
        skid_text <= res.text;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds data with output empty");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !skid_valid)
    else $error("result arrived with both slots full");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid filled while output drained");

endmodule

// ----- hw/rtl/checksum_frame_deframer_top.sv -----
// Channel   Direction  Handshake               Payload
// in        in         in_valid / in_stall     rx_byte[7:0]
// out       out        out_valid / out_stall   reading_text[55:0]
// cfg       in         cfg_valid / cfg_ready   cfg_index[1:0], cfg_data[15:0]
//
// One byte per cycle unless stalled; a good frame's result registers with its last byte.
// Frame state and the running checksum update in a single register stage.
// A two-entry output buffer absorbs results; in_stall rises only when both entries hold.
// Synchronous reset returns to hunting and restores register defaults.
module checksum_frame_deframer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cfd_pkg::TEXT_W-1:0]      reading_text,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cfd_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    full;
  logic    accept;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  cfd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .res     (res)
  );

  cfd_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .full         (full),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .reading_text (reading_text)
  );

endmodule
